[design/dec96_pkg.sv]
// Package with request/result types and constants for the decimal multiplier.
`timescale 1ns / 1ps
package dec96_pkg;

  localparam int unsigned MantW  = 96;
  localparam int unsigned LimbW  = 32;
  localparam logic [5:0]  MaxScale = 6'd28;

  typedef enum logic [1:0] {
    StatusOk       = 2'd0,
    StatusTooLarge = 2'd1,
    StatusTooSmall = 2'd2
  } status_e;

  typedef struct packed {
    logic [63:0] a_mant_low;
    logic [31:0] a_mant_high;
    logic [4:0]  a_scale;
    logic        a_sign;
    logic [63:0] b_mant_low;
    logic [31:0] b_mant_high;
    logic [4:0]  b_scale;
    logic        b_sign;
  } req_t;

  typedef struct packed {
    logic [63:0] prod_mant_low;
    logic [31:0] prod_mant_high;
    logic [5:0]  prod_scale;
    logic        prod_sign;
    logic [1:0]  status;
  } res_t;

endpackage

[design/dec96_div10.sv]
// Divides one 32-bit limb plus running remainder by ten.
`timescale 1ns / 1ps
module dec96_div10 (
  input  logic [31:0] limb_i,
  input  logic [3:0]  rem_i,
  output logic [31:0] quot_o,
  output logic [3:0]  rem_o
);
  import dec96_pkg::*;

  logic [35:0] cur;
  logic [71:0] prod;
  logic [35:0] q_est;
  logic [39:0] back;
  logic [39:0] diff;

  // Reciprocal multiply: floor(x*ceil(2^39/10)/2^39) is exact for x below 2^36.
  always_comb begin
    cur   = {rem_i, limb_i};
    prod  = {36'd0, cur} * 72'd54975581389;
    q_est = {3'd0, prod[71:39]};
    back  = {4'd0, q_est} * 40'd10;
    diff  = {4'd0, cur} - back;
    quot_o = q_est[31:0];
    rem_o  = diff[3:0];
  end

endmodule

[design/decimal96_multiply_round.sv]
// Top level: iterative 96x96 decimal multiply with scale reduction and rounding.
//
//   channel | signals                 | direction | handshake
//   request | start_i, req_i          | in        | accepted when start_i && !busy_o
//   result  | done_o, res_o           | out       | one-cycle strobe, no stall
//
// An item passes acceptance, nine 32x32 partial products through one multiplier,
// one overflow check, then per decimal step three limb divisions through one
// divider and one rounding step (k steps, k being the summed scale minus 28, at
// most 34), and a final state that registers the result; the done strobe is
// registered together with the result.
// Reset clears the sequencer and strobe; the result is not held back by the
// receiver, and busy_o stays high from acceptance until the done strobe.
`timescale 1ns / 1ps
module decimal96_multiply_round (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  dec96_pkg::req_t req_i,
  output logic            busy_o,
  output logic            done_o,
  output dec96_pkg::res_t res_o
);
  import dec96_pkg::*;

  typedef enum logic [2:0] {
    StIdle, StMul, StCheck, StDiv, StRound, StDone
  } state_e;

  state_e      state_q;
  logic [95:0] a_q, b_q;
  logic [191:0] acc_q;
  logic [1:0]  i_q, j_q;
  logic [5:0]  scale_q;
  logic        sign_q;
  logic [1:0]  status_q;
  logic [95:0] m_q;
  logic [1:0]  limb_q;
  logic [3:0]  rem_q;
  logic        done_q;
  res_t        res_q;

  // Shared multiplier on one limb pair.
  logic [31:0] a_limb, b_limb;
  logic [63:0] pp;
  logic [7:0]  sh;
  logic [191:0] pp_w;
  always_comb begin
    a_limb = a_q[{i_q, 5'd0} +: 32];
    b_limb = b_q[{j_q, 5'd0} +: 32];
    pp     = {32'd0, a_limb} * {32'd0, b_limb};
    sh     = {({1'b0, i_q} + {1'b0, j_q}), 5'd0};
    pp_w   = {128'd0, pp} << sh;
  end

  // Shared divider on one limb.
  logic [31:0] q_limb;
  logic [3:0]  q_rem;
  dec96_div10 u_div (
    .limb_i (m_q[{limb_q, 5'd0} +: 32]),
    .rem_i  (rem_q),
    .quot_o (q_limb),
    .rem_o  (q_rem)
  );

  logic        rnd_up;
  logic [95:0] m_inc;
  always_comb begin
    rnd_up = (rem_q > 4'd5) || ((rem_q == 4'd5) && m_q[0]);
    m_inc  = m_q + {95'd0, rnd_up};
  end

  // Sequencer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      done_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        StIdle: begin
          if (start_i) begin
            a_q      <= {req_i.a_mant_high, req_i.a_mant_low};
            b_q      <= {req_i.b_mant_high, req_i.b_mant_low};
            scale_q  <= {1'b0, req_i.a_scale} + {1'b0, req_i.b_scale};
            sign_q   <= req_i.a_sign ^ req_i.b_sign;
            acc_q    <= '0;
            i_q      <= 2'd0;
            j_q      <= 2'd0;
            status_q <= StatusOk;
            state_q  <= StMul;
          end
        end
        StMul: begin
          acc_q <= acc_q + pp_w;
          if (j_q == 2'd2) begin
            j_q <= 2'd0;
            if (i_q == 2'd2) state_q <= StCheck;
            else i_q <= i_q + 2'd1;
          end else begin
            j_q <= j_q + 2'd1;
          end
        end
        StCheck: begin
          m_q <= acc_q[95:0];
          limb_q <= 2'd2;
          rem_q  <= 4'd0;
          if (acc_q[191:96] != '0) begin
            status_q <= StatusTooLarge;
            state_q  <= StDone;
          end else if (scale_q > MaxScale) begin
            state_q <= StDiv;
          end else begin
            state_q <= StDone;
          end
        end
        StDiv: begin
          m_q[{limb_q, 5'd0} +: 32] <= q_limb;
          rem_q <= q_rem;
          if (limb_q == 2'd0) state_q <= StRound;
          else limb_q <= limb_q - 2'd1;
        end
        StRound: begin
          m_q     <= m_inc;
          scale_q <= scale_q - 6'd1;
          limb_q  <= 2'd2;
          rem_q   <= 4'd0;
          if (m_inc == '0) begin
            status_q <= StatusTooSmall;
            state_q  <= StDone;
          end else if (scale_q - 6'd1 > MaxScale) begin
            state_q <= StDiv;
          end else begin
            state_q <= StDone;
          end
        end
        StDone: begin
          res_q.prod_mant_low  <= m_q[63:0];
          res_q.prod_mant_high <= m_q[95:64];
          res_q.prod_scale     <= scale_q;
          res_q.prod_sign      <= sign_q;
          res_q.status         <= status_q;
          done_q  <= 1'b1;
          state_q <= StIdle;
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  assign busy_o = (state_q != StIdle);
  assign done_o = done_q;
  assign res_o  = res_q;

  // Checks on the sequencer.
  a_done_after_done_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(state_q == StDone)) else $error("done without finish state");
  a_small_is_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_q && res_q.status == StatusTooSmall) |-> (res_q.prod_mant_low == '0))
    else $error("too small with nonzero mantissa");
  a_ok_scale: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_q && res_q.status == StatusOk) |-> (res_q.prod_scale <= MaxScale))
    else $error("ok result with scale above limit");

endmodule
